// File: src/kpsd_pkg.sv
// Shared types and constants for the keypad scan, debounce and auto-repeat block.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package kpsd_pkg;

  localparam int TimeBits     = 32;
  localparam int MatrixBits   = 25;
  localparam int KeyBits      = 5;
  localparam int CfgBits      = 16;
  localparam int CfgIndexBits = 8;
  localparam int DivSteps     = 32;
  localparam int QueueDepth   = 2;
  localparam int DefRows      = 5;
  localparam int DefCols      = 5;

  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE     = 8'd0;
  localparam logic [CfgIndexBits-1:0] REG_REPEAT_DELAY = 8'd1;
  localparam logic [CfgIndexBits-1:0] REG_REPEAT_PER   = 8'd2;
  localparam logic [CfgIndexBits-1:0] REG_REPEAT_WIN   = 8'd3;

  localparam logic [CfgBits-1:0] RST_DEBOUNCE     = 16'd50;
  localparam logic [CfgBits-1:0] RST_REPEAT_DELAY = 16'd500;
  localparam logic [CfgBits-1:0] RST_REPEAT_PER   = 16'd150;
  localparam logic [CfgBits-1:0] RST_REPEAT_WIN   = 16'd20;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_HOLD     = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_t;

  // EV_HOLD here means "hold candidate": the back end still runs the window test.
  typedef struct packed {
    event_kind_t         kind;
    logic [KeyBits-1:0]  key;
    logic [TimeBits-1:0] past;
  } cmd_t;

  typedef struct packed {
    logic [CfgBits-1:0] period;
    logic [CfgBits-1:0] window;
  } back_cfg_t;

endpackage
`default_nettype wire

// File: src/kpsd_ifs.sv
// Channel interfaces: poll input, event report output and register write port.
// Depends on kpsd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kpsd_in_if;
  logic                                valid;
  logic                                ready;
  logic [kpsd_pkg::TimeBits-1:0]       now_ms;
  logic [kpsd_pkg::MatrixBits-1:0]     pressed_matrix;
  modport source (output valid, now_ms, pressed_matrix, input ready);
  modport sink (input valid, now_ms, pressed_matrix, output ready);
endinterface

interface kpsd_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          event_kind;
  logic [kpsd_pkg::KeyBits-1:0]        key_index;
  modport source (output valid, event_kind, key_index, input ready);
  modport sink (input valid, event_kind, key_index, output ready);
endinterface

interface kpsd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kpsd_pkg::CfgIndexBits-1:0]   index;
  logic [kpsd_pkg::CfgBits-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/kpsd_front.sv
// Front end: register file, key priority encoder, held-key state and event classification.
// Depends on kpsd_pkg and kpsd_ifs; feeds commands to kpsd_queue.
`timescale 1ns / 1ps
`default_nettype none
module kpsd_front #(
  parameter int ROWS = kpsd_pkg::DefRows,
  parameter int COLS = kpsd_pkg::DefCols
) (
  input  wire logic                clk,
  input  wire logic                rst,
  kpsd_in_if.sink                  poll,
  kpsd_cfg_if.sink                 cfg,
  output kpsd_pkg::cmd_t           cmd,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output kpsd_pkg::back_cfg_t      back_cfg
);

  localparam int Keys = (ROWS * COLS > kpsd_pkg::MatrixBits) ? kpsd_pkg::MatrixBits
                                                             : ROWS * COLS;

  logic [kpsd_pkg::CfgBits-1:0]  debounce_lim;
  logic [kpsd_pkg::CfgBits-1:0]  repeat_delay;
  logic [kpsd_pkg::CfgBits-1:0]  repeat_period_ms;
  logic [kpsd_pkg::CfgBits-1:0]  repeat_window_ms;

  logic                          held_valid;
  logic [kpsd_pkg::KeyBits-1:0]  held_index;
  logic [kpsd_pkg::TimeBits-1:0] accept_time;

  logic                          found;
  logic [kpsd_pkg::KeyBits-1:0]  key;
  logic [kpsd_pkg::TimeBits-1:0] hold;
  logic [kpsd_pkg::TimeBits-1:0] past;
  logic                          xfer;

  assign cfg.ready = 1'b1;
  assign back_cfg  = {repeat_period_ms, repeat_window_ms};

  assign poll.ready = cmd_ready;
  assign cmd_valid  = poll.valid;
  assign xfer       = poll.valid && cmd_ready;

  always_comb begin
    found = 1'b0;
    key   = '0;
    for (int i = Keys - 1; i >= 0; i--) begin
      if (poll.pressed_matrix[i]) begin
        found = 1'b1;
        key   = kpsd_pkg::KeyBits'(i);
      end
    end
  end

  assign hold = poll.now_ms - accept_time;
  assign past = hold - {16'd0, repeat_delay};

  always_comb begin
    cmd.kind = kpsd_pkg::EV_NONE;
    cmd.key  = '0;
    cmd.past = past;
    if (!found) begin
      if (held_valid) begin
        cmd.kind = kpsd_pkg::EV_RELEASED;
      end
    end else if (!held_valid || key != held_index) begin
      if (hold > {16'd0, debounce_lim}) begin
        cmd.kind = kpsd_pkg::EV_PRESSED;
        cmd.key  = key;
      end
    end else if (hold > {16'd0, repeat_delay}) begin
      cmd.kind = kpsd_pkg::EV_HOLD;
      cmd.key  = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_lim     <= kpsd_pkg::RST_DEBOUNCE;
      repeat_delay     <= kpsd_pkg::RST_REPEAT_DELAY;
      repeat_period_ms <= kpsd_pkg::RST_REPEAT_PER;
      repeat_window_ms <= kpsd_pkg::RST_REPEAT_WIN;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        kpsd_pkg::REG_DEBOUNCE:     debounce_lim     <= cfg.data;
        kpsd_pkg::REG_REPEAT_DELAY: repeat_delay     <= cfg.data;
        kpsd_pkg::REG_REPEAT_PER:   repeat_period_ms <= cfg.data;
        kpsd_pkg::REG_REPEAT_WIN:   repeat_window_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  // Release keeps accept_time so debounce still counts from the last accepted key.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_index  <= '0;
      accept_time <= '0;
    end else if (xfer) begin
      if (cmd.kind == kpsd_pkg::EV_PRESSED) begin
        held_valid  <= 1'b1;
        held_index  <= key;
        accept_time <= poll.now_ms;
      end else if (cmd.kind == kpsd_pkg::EV_RELEASED) begin
        held_valid  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/kpsd_queue.sv
// Short command queue between front and back ends.
// Depends on kpsd_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none
module kpsd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire kpsd_pkg::cmd_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output kpsd_pkg::cmd_t       pop_data
);

  localparam int PtrBits = (kpsd_pkg::QueueDepth > 1) ? $clog2(kpsd_pkg::QueueDepth) : 1;
  localparam int CntBits = $clog2(kpsd_pkg::QueueDepth + 1);

  kpsd_pkg::cmd_t       mem [kpsd_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CntBits-1:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = count != CntBits'(kpsd_pkg::QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(kpsd_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(kpsd_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/kpsd_back.sv
// Back end: bit-serial remainder unit for the repeat window test and the report register.
// Depends on kpsd_pkg and kpsd_ifs; takes commands from kpsd_queue.
`timescale 1ns / 1ps
`default_nettype none
module kpsd_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire kpsd_pkg::cmd_t        cmd,
  input  wire kpsd_pkg::back_cfg_t   back_cfg,
  kpsd_out_if.source                 report
);

  localparam int CntBits = $clog2(kpsd_pkg::DivSteps);

  kpsd_pkg::back_state_t         state;
  kpsd_pkg::back_state_t         state_next;

  logic                          out_valid;
  kpsd_pkg::event_kind_t         out_kind;
  logic [kpsd_pkg::KeyBits-1:0]  out_key;
  logic [kpsd_pkg::TimeBits-1:0] dvd;
  logic [kpsd_pkg::CfgBits-1:0]  rem;
  logic [CntBits-1:0]            cnt;
  logic [kpsd_pkg::KeyBits-1:0]  hold_key;

  logic                          out_free;
  logic [kpsd_pkg::CfgBits:0]    rem_sh;
  logic [kpsd_pkg::CfgBits-1:0]  rem_sub;
  logic [kpsd_pkg::CfgBits-1:0]  rem_step;
  logic                          needs_div;
  kpsd_pkg::event_kind_t         direct_kind;
  logic                          start_div;
  logic                          step;
  logic                          load;
  kpsd_pkg::event_kind_t         load_kind;
  logic [kpsd_pkg::KeyBits-1:0]  load_key;

  assign report.valid      = out_valid;
  assign report.event_kind = out_kind;
  assign report.key_index  = out_key;

  assign out_free = !out_valid || report.ready;

  assign rem_sh   = {rem, dvd[kpsd_pkg::TimeBits-1]};
  assign rem_sub  = rem_sh[kpsd_pkg::CfgBits-1:0] - back_cfg.period;
  assign rem_step = (rem_sh >= {1'b0, back_cfg.period}) ? rem_sub
                                                        : rem_sh[kpsd_pkg::CfgBits-1:0];

  // Zero period: remainder is the dividend itself, so compare directly.
  assign needs_div = cmd.kind == kpsd_pkg::EV_HOLD && back_cfg.period != '0;

  always_comb begin
    direct_kind = cmd.kind;
    if (cmd.kind == kpsd_pkg::EV_HOLD) begin
      direct_kind = (cmd.past < {16'd0, back_cfg.window}) ? kpsd_pkg::EV_HOLD
                                                           : kpsd_pkg::EV_NONE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kpsd_pkg::BK_IDLE:   if (start_div) state_next = kpsd_pkg::BK_DIVIDE;
      kpsd_pkg::BK_DIVIDE: if (cnt == CntBits'(kpsd_pkg::DivSteps - 1)) begin
        state_next = kpsd_pkg::BK_FINISH;
      end
      kpsd_pkg::BK_FINISH: if (out_free) state_next = kpsd_pkg::BK_IDLE;
      default:             state_next = kpsd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    start_div = 1'b0;
    step      = 1'b0;
    load      = 1'b0;
    load_kind = kpsd_pkg::EV_NONE;
    load_key  = '0;
    unique case (state)
      kpsd_pkg::BK_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          if (needs_div) begin
            start_div = 1'b1;
          end else begin
            load      = 1'b1;
            load_kind = direct_kind;
            load_key  = (direct_kind == kpsd_pkg::EV_NONE) ? '0 : cmd.key;
          end
        end
      end
      kpsd_pkg::BK_DIVIDE: begin
        step = 1'b1;
      end
      kpsd_pkg::BK_FINISH: begin
        if (out_free) begin
          load = 1'b1;
          if (rem < back_cfg.window) begin
            load_kind = kpsd_pkg::EV_HOLD;
            load_key  = hold_key;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kpsd_pkg::BK_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
      if (start_div) begin
        cnt <= '0;
      end else if (step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= load_kind;
      out_key  <= load_key;
    end
    if (start_div) begin
      dvd      <= cmd.past;
      rem      <= '0;
      hold_key <= cmd.key;
    end else if (step) begin
      dvd <= {dvd[kpsd_pkg::TimeBits-2:0], 1'b0};
      rem <= rem_step;
    end
  end

endmodule
`default_nettype wire

// File: src/keypad_scan_debounce_repeat.sv
// Top level of the keypad scanner with debounce and auto-repeat.
// Depends on kpsd_pkg, kpsd_ifs, kpsd_front, kpsd_queue and kpsd_back.
`timescale 1ns / 1ps
`default_nettype none
// Each poll transfer (timestamp plus key matrix) yields exactly one report transfer:
// none, pressed, released or hold. The front end classifies a poll and updates the
// held-key state in the cycle it is taken, so it can take a poll every cycle while
// the two-entry command queue has room. Pressed, released and none reports pass the
// queue register and then the back end report register. A held-key poll past the
// repeat delay needs the remainder of the time past the delay by the repeat period
// (when nonzero): the back end runs a one-bit-per-cycle restoring divider, takes no
// new command until that report is loaded, and so sets the sustained held-key rate.
// Registers are written through the cfg channel, which is always ready.
module keypad_scan_debounce_repeat #(
  parameter int ROWS = kpsd_pkg::DefRows,
  parameter int COLS = kpsd_pkg::DefCols
) (
  input  wire logic   clk,
  input  wire logic   rst,
  kpsd_in_if.sink     poll,
  kpsd_out_if.source  report,
  kpsd_cfg_if.sink    cfg
);

  kpsd_pkg::cmd_t       front_cmd;
  logic                 front_valid;
  logic                 front_ready;
  kpsd_pkg::cmd_t       back_cmd;
  logic                 back_valid;
  logic                 back_ready;
  kpsd_pkg::back_cfg_t  back_cfg;

  kpsd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll),
    .cfg       (cfg),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .back_cfg  (back_cfg)
  );

  kpsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  kpsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .back_cfg  (back_cfg),
    .report    (report)
  );

endmodule
`default_nettype wire
